### rtl/ssmd_pkg.sv
// Package for the seven-segment multiplexed display driver.
// Word types, segment tables and codes. No dependencies.
package ssmd_pkg;

  // Input word: load or refresh tick
  typedef struct packed {
    logic        action;
    logic [19:0] value;
    logic [1:0]  unit_select;
  } in_word_t;

  // Result word: one shift-register pin step
  typedef struct packed {
    logic       serial_data;
    logic       shift_pulse;
    logic       latch_pulse;
    logic [3:0] digit_enable_n;
    logic       last;
  } out_word_t;

  // Action codes
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REFRESH = 1'b1;

  // Unit codes
  localparam logic [1:0] UNIT_V = 2'd0;
  localparam logic [1:0] UNIT_A = 2'd1;
  localparam logic [1:0] UNIT_W = 2'd2;

  // Reciprocal constants for divide-by-constant
  localparam logic [19:0] RECIP_10_W20  = 20'd838861;  // /10, shift 23
  localparam logic [17:0] RECIP_1000    = 18'd134218;  // /1000, shift 27
  localparam logic [7:0]  RECIP_10_SMALL = 8'd205;     // /10, shift 11

  localparam logic [7:0] DP_MASK     = 8'h80;
  localparam logic [7:0] RESET_UNIT  = 8'h3E;
  localparam logic [3:0] RESET_EN    = 4'h7;
  localparam logic [3:0] LAST_BIT    = 4'd8;

  // Decimal digit to segment pattern
  function automatic logic [7:0] digit_pattern(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Unit code to letter pattern
  function automatic logic [7:0] unit_pattern(input logic [1:0] u);
    logic [7:0] p;
    unique case (u)
      UNIT_V:  p = 8'h3E;
      UNIT_A:  p = 8'h77;
      UNIT_W:  p = 8'h73;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Scan position to active-low digit enables
  function automatic logic [3:0] enable_for(input logic [1:0] pos);
    return ~(4'b1000 >> pos);
  endfunction

endpackage

### rtl/seven_segment_mux_driver.sv
// Top level of the seven-segment multiplexed display driver.
// Depends on ssmd_pkg (word types, tables, codes).
//
//  channel | dir | handshake           | word type
//  in      | in  | in_valid / in_stall  | ssmd_pkg::in_word_t
//  out     | out | out_valid / out_stall| ssmd_pkg::out_word_t
//
// A load word runs through a five-stage conversion pipeline (/10, mod 1000,
// digit split) and yields no result; loads are taken every cycle unless a
// waiting tick holds the input register. A refresh tick yields nine words
// from the shift sequencer; the next tick is taken as the ninth word goes
// out, and a tick waits in the input register until earlier loads reach the store.
// Reset (rst_n low, synchronous) shows the unit letter U on display four.
// out_stall holds the output register; the sequencer waits, and so does a tick in the input stage.
module seven_segment_mux_driver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssmd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ssmd_pkg::out_word_t out_word
);

  // ---------------- input register ----------------
  logic               in_v_r;
  ssmd_pkg::in_word_t in_w_r;
  logic               adv;
  logic               load_pend;
  logic               gen_free;

  assign adv      = in_v_r && ((in_w_r.action == ssmd_pkg::ACT_LOAD) ||
                               (gen_free && !load_pend));
  assign in_stall = in_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_w_r <= in_word;
    end
  end

  logic take_load, take_tick;
  assign take_load = adv && (in_w_r.action == ssmd_pkg::ACT_LOAD);
  assign take_tick = adv && (in_w_r.action == ssmd_pkg::ACT_REFRESH);

  // ---------------- load pipeline ----------------
  logic        p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  logic [16:0] p1_q_r, p2_q_r;
  logic [6:0]  p2_t_r;
  logic [9:0]  p3_r_r;
  logic [6:0]  p4_a_r;
  logic [3:0]  p4_d1_r;
  logic [1:0]  p1_u_r, p2_u_r, p3_u_r, p4_u_r;

  assign load_pend = p1_v_r || p2_v_r || p3_v_r || p4_v_r;

  // stage 1: q = value / 10
  logic [39:0] prod_q;
  assign prod_q = 40'(in_w_r.value) * 40'(ssmd_pkg::RECIP_10_W20);

  // stage 2: t = q / 1000
  logic [34:0] prod_t;
  assign prod_t = 35'(p1_q_r) * 35'(ssmd_pkg::RECIP_1000);

  // stage 3: r = q - 1000 t
  logic [16:0] t_times_k;
  logic [16:0] rem_full;
  assign t_times_k = (17'(p2_t_r) << 10) - (17'(p2_t_r) << 4) - (17'(p2_t_r) << 3);
  assign rem_full  = p2_q_r - t_times_k;

  // stage 4: a = r / 10, d1 = r mod 10
  logic [17:0] prod_a;
  logic [6:0]  a_val;
  logic [9:0]  a_times_ten;
  logic [9:0]  d1_full;
  assign prod_a      = 18'(p3_r_r) * 18'(ssmd_pkg::RECIP_10_SMALL);
  assign a_val       = prod_a[17:11];
  assign a_times_ten = (10'(a_val) << 3) + (10'(a_val) << 1);
  assign d1_full     = p3_r_r - a_times_ten;

  // stage 5: b = a / 10, d2 = a mod 10, d3 = b
  logic [14:0] prod_b;
  logic [3:0]  b_val;
  logic [6:0]  b_times_ten;
  logic [6:0]  d2_full;
  assign prod_b      = 15'(p4_a_r) * 15'(ssmd_pkg::RECIP_10_SMALL);
  assign b_val       = prod_b[14:11];
  assign b_times_ten = (7'(b_val) << 3) + (7'(b_val) << 1);
  assign d2_full     = p4_a_r - b_times_ten;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else begin
      p1_v_r <= take_load;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_q_r  <= prod_q[39:23];
    p1_u_r  <= in_w_r.unit_select;
    p2_q_r  <= p1_q_r;
    p2_t_r  <= prod_t[33:27];
    p2_u_r  <= p1_u_r;
    p3_r_r  <= rem_full[9:0];
    p3_u_r  <= p2_u_r;
    p4_a_r  <= a_val;
    p4_d1_r <= d1_full[3:0];
    p4_u_r  <= p3_u_r;
  end

  // ---------------- segment store ----------------
  logic [7:0] seg_r [4];
  logic [7:0] seg_nxt [4];

  always_comb begin
    seg_nxt[0] = ssmd_pkg::unit_pattern(p4_u_r);
    seg_nxt[1] = ssmd_pkg::digit_pattern(p4_d1_r);
    seg_nxt[2] = ssmd_pkg::digit_pattern(d2_full[3:0]);
    seg_nxt[3] = ssmd_pkg::digit_pattern(b_val);
    // decimal point depends on the unit
    if (p4_u_r == ssmd_pkg::UNIT_V) begin
      seg_nxt[2] = seg_nxt[2] | ssmd_pkg::DP_MASK;
    end else if (p4_u_r == ssmd_pkg::UNIT_A || p4_u_r == ssmd_pkg::UNIT_W) begin
      seg_nxt[3] = seg_nxt[3] | ssmd_pkg::DP_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r[0] <= ssmd_pkg::RESET_UNIT;
      seg_r[1] <= 8'h00;
      seg_r[2] <= 8'h00;
      seg_r[3] <= 8'h00;
    end else if (p4_v_r) begin
      for (int i = 0; i < 4; i++) begin
        seg_r[i] <= seg_nxt[i];
      end
    end
  end

  // ---------------- scan state ----------------
  logic [1:0] scan_r;
  logic [3:0] en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= 2'd0;
      en_r   <= ssmd_pkg::RESET_EN;
    end else if (take_tick) begin
      scan_r <= scan_r + 2'd1;
      en_r   <= ssmd_pkg::enable_for(scan_r);
    end
  end

  // ---------------- shift sequencer ----------------
  logic       gen_busy_r;
  logic [3:0] gen_cnt_r;
  logic [7:0] gen_pat_r;
  logic [3:0] gen_old_r;
  logic [3:0] gen_new_r;
  logic       out_load;
  logic       gen_emit;
  logic       gen_done;

  assign out_load = !out_valid || !out_stall;
  assign gen_emit = gen_busy_r && out_load;
  assign gen_done = gen_emit && (gen_cnt_r == ssmd_pkg::LAST_BIT);
  assign gen_free = !gen_busy_r || gen_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_busy_r <= 1'b0;
      gen_cnt_r  <= 4'd0;
    end else if (take_tick) begin
      gen_busy_r <= 1'b1;
      gen_cnt_r  <= 4'd0;
    end else if (gen_emit) begin
      gen_busy_r <= !gen_done;
      gen_cnt_r  <= gen_cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      gen_pat_r <= seg_r[scan_r];
      gen_old_r <= en_r;
      gen_new_r <= ssmd_pkg::enable_for(scan_r);
    end
  end

  // word for the current step
  ssmd_pkg::out_word_t gen_word;
  always_comb begin
    if (gen_cnt_r == ssmd_pkg::LAST_BIT) begin
      gen_word.serial_data    = 1'b0;
      gen_word.shift_pulse    = 1'b0;
      gen_word.latch_pulse    = 1'b1;
      gen_word.digit_enable_n = gen_new_r;
      gen_word.last           = 1'b1;
    end else begin
      gen_word.serial_data    = gen_pat_r[3'd7 - gen_cnt_r[2:0]];
      gen_word.shift_pulse    = 1'b1;
      gen_word.latch_pulse    = 1'b0;
      gen_word.digit_enable_n = gen_old_r;
      gen_word.last           = 1'b0;
    end
  end

  // ---------------- output register ----------------
  logic                out_v_r;
  ssmd_pkg::out_word_t out_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= gen_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_emit) begin
      out_w_r <= gen_word;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_w_r;

endmodule

### rtl/ssmd_checker.sv
// Port checker for the seven-segment display driver, bound to the top level.
// Depends on ssmd_pkg (result word type).
module ssmd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input ssmd_pkg::out_word_t out_word
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("out word changed while stalled");

  // latch only on the closing word
  a_latch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.latch_pulse |-> out_word.last)
    else $error("latch pulse without last");

  // shift words never latch or close the tick
  a_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.shift_pulse |-> !out_word.latch_pulse && !out_word.last)
    else $error("shift word carries latch or last");

  // exactly one display on in every word
  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(~out_word.digit_enable_n) == 1)
    else $error("digit enables not one-cold");

endmodule

bind seven_segment_mux_driver ssmd_checker u_ssmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
